[rtl/idq_pkg.sv]
// Shared constants, opcodes, status codes and the response bundle of the
// indexed double-ended queue. No dependencies.
`timescale 1ns / 1ps

package idq_pkg;

  // Ring arithmetic wraps by truncation, so CAPACITY stays a power of two.
  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int STAT_W     = 2;

  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd5;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic                  done;
    logic [ITEM_WIDTH-1:0] read_value;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      occupancy;
  } idq_resp_t;

endpackage

[rtl/idq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module idq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/idq_seq.sv]
// Request sequencer: head pointer, item count and the read-modify-write
// steps that move entries of the item RAM. Depends on idq_pkg.
`timescale 1ns / 1ps

module idq_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic [idq_pkg::OP_W-1:0]        opcode_i,
  input  logic [idq_pkg::ITEM_WIDTH-1:0]  item_value_i,
  input  logic [idq_pkg::POS_W-1:0]       position_i,
  input  logic [idq_pkg::POS_W-1:0]       run_length_i,
  output logic                            busy,
  output idq_pkg::idq_resp_t              resp_o,
  output logic                            ram_we_o,
  output logic [idq_pkg::PTR_W-1:0]       ram_waddr_o,
  output logic [idq_pkg::ITEM_WIDTH-1:0]  ram_wdata_o,
  output logic [idq_pkg::PTR_W-1:0]       ram_raddr_o,
  input  logic [idq_pkg::ITEM_WIDTH-1:0]  ram_rdata_i
);
  import idq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_SH_RD = 3'd3;
  localparam logic [2:0] S_SH_WR = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;

  logic [OP_W-1:0]       op_q, op_d;
  logic [ITEM_WIDTH-1:0] val_q, val_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [POS_W-1:0]      run_q, run_d;
  logic [PTR_W-1:0]      cur_q, cur_d;
  logic [PTR_W-1:0]      off_q, off_d;
  logic                  down_q, down_d;
  logic                  front_q, front_d;
  logic [CNT_W-1:0]      left_q, left_d;
  logic [ITEM_WIDTH-1:0] rd_q, rd_d;
  logic [STAT_W-1:0]     stat_q, stat_d;

  logic                  full;
  logic [CNT_W-1:0]      tail_room;
  logic [CNT_W-1:0]      run_eff;
  logic [CNT_W-1:0]      after;

  assign full      = (count_q >= CNT_W'(CAPACITY));
  assign tail_room = count_q - CNT_W'(pos_q);
  assign run_eff   = (CNT_W'(run_q) > tail_room) ? tail_room : CNT_W'(run_q);
  assign after     = tail_room - run_eff;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    run_d       = run_q;
    cur_d       = cur_q;
    off_d       = off_q;
    down_d      = down_q;
    front_d     = front_q;
    left_d      = left_q;
    rd_d        = rd_q;
    stat_d      = stat_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q + cur_q + off_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = head_q + cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = opcode_i;
          val_d   = item_value_i;
          pos_d   = position_i;
          run_d   = run_length_i;
          rd_d    = '0;
          stat_d  = STAT_OK;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        unique case (op_q)
          OP_PUSH_HEAD: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = head_q - PTR_W'(1);
              ram_wdata_o = val_q;
              head_d      = head_q - PTR_W'(1);
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_PUSH_TAIL: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = head_q + count_q[PTR_W-1:0];
              ram_wdata_o = val_q;
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_POP_HEAD: begin
            if (count_q == '0) begin
              stat_d = STAT_EMPTY;
            end else begin
              ram_raddr_o = head_q;
              state_d     = S_WAIT;
            end
          end
          OP_POP_TAIL: begin
            if (count_q == '0) begin
              stat_d = STAT_EMPTY;
            end else begin
              ram_raddr_o = head_q + PTR_W'(count_q - CNT_W'(1));
              state_d     = S_WAIT;
            end
          end
          OP_READ: begin
            if (CNT_W'(pos_q) >= count_q) begin
              stat_d = STAT_RANGE;
            end else begin
              ram_raddr_o = head_q + pos_q[PTR_W-1:0];
              state_d     = S_WAIT;
            end
          end
          OP_INSERT: begin
            if (CNT_W'(pos_q) >= count_q) begin
              stat_d = STAT_RANGE;
            end else if (full) begin
              stat_d = STAT_FULL;
            end else begin
              // move entries pos..count-1 one slot toward the tail, top first
              cur_d   = PTR_W'(count_q - CNT_W'(1));
              off_d   = PTR_W'(1);
              down_d  = 1'b1;
              left_d  = tail_room;
              state_d = S_SH_RD;
            end
          end
          OP_REMOVE: begin
            if (CNT_W'(pos_q) > count_q) begin
              stat_d = STAT_RANGE;
            end else if (run_eff != '0) begin
              run_d = POS_W'(run_eff);
              if (CNT_W'(pos_q) < after) begin
                // shift the head side forward by the run
                front_d = 1'b1;
                cur_d   = PTR_W'(pos_q - POS_W'(1));
                off_d   = run_eff[PTR_W-1:0];
                down_d  = 1'b1;
                left_d  = CNT_W'(pos_q);
                state_d = (pos_q == '0) ? S_FIN : S_SH_RD;
              end else begin
                // pull the tail side back over the run
                front_d = 1'b0;
                cur_d   = pos_q[PTR_W-1:0] + run_eff[PTR_W-1:0];
                off_d   = PTR_W'(0) - run_eff[PTR_W-1:0];
                down_d  = 1'b0;
                left_d  = after;
                state_d = (after == '0) ? S_FIN : S_SH_RD;
              end
            end
          end
          default: begin
            head_d  = '0;
            count_d = '0;
          end
        endcase
      end

      S_WAIT: begin
        rd_d = ram_rdata_i;
        if (op_q == OP_POP_HEAD) begin
          head_d  = head_q + PTR_W'(1);
          count_d = count_q - CNT_W'(1);
        end else if (op_q == OP_POP_TAIL) begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = S_RESP;
      end

      S_SH_RD: begin
        state_d = S_SH_WR;
      end

      S_SH_WR: begin
        ram_we_o = 1'b1;
        left_d   = left_q - CNT_W'(1);
        cur_d    = down_q ? (cur_q - PTR_W'(1)) : (cur_q + PTR_W'(1));
        state_d  = (left_q == CNT_W'(1)) ? S_FIN : S_SH_RD;
      end

      S_FIN: begin
        if (op_q == OP_INSERT) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = head_q + pos_q[PTR_W-1:0];
          ram_wdata_o = val_q;
          count_d     = count_q + CNT_W'(1);
        end else begin
          if (front_q) begin
            head_d = head_q + run_q[PTR_W-1:0];
          end
          count_d = count_q - CNT_W'(run_q);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    pos_q   <= pos_d;
    run_q   <= run_d;
    cur_q   <= cur_d;
    off_q   <= off_d;
    down_q  <= down_d;
    front_q <= front_d;
    left_q  <= left_d;
    rd_q    <= rd_d;
    stat_q  <= stat_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign resp_o.done       = (state_q == S_RESP);
  assign resp_o.read_value = rd_q;
  assign resp_o.status     = stat_q;
  assign resp_o.occupancy  = count_q;

endmodule

[rtl/indexed_double_ended_queue_unit.sv]
// Top level: bounded double-ended queue with indexed read, insert and remove.
// A request passes through EXEC and RESP for push, clear, failed requests and
// removes of an empty run; pop and read add WAIT for the RAM read; insert and
// remove add SH_RD, SH_WR per moved entry (one RAM read, one write), then FIN.
// A new request is taken in the cycle after done_o. Reset clears head and count;
// the item RAM is not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module indexed_double_ended_queue_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [idq_pkg::OP_W-1:0]       opcode_i,
  input  logic [idq_pkg::ITEM_WIDTH-1:0] item_value_i,
  input  logic [idq_pkg::POS_W-1:0]      position_i,
  input  logic [idq_pkg::POS_W-1:0]      run_length_i,
  output logic                           done_o,
  output logic [idq_pkg::ITEM_WIDTH-1:0] read_value_o,
  output logic [idq_pkg::STAT_W-1:0]     status_o,
  output logic [idq_pkg::CNT_W-1:0]      occupancy_o
);
  import idq_pkg::*;

  idq_resp_t             resp;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [ITEM_WIDTH-1:0] ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  idq_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .opcode_i     (opcode_i),
    .item_value_i (item_value_i),
    .position_i   (position_i),
    .run_length_i (run_length_i),
    .busy         (busy),
    .resp_o       (resp),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  idq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o       = resp.done;
  assign read_value_o = resp.read_value;
  assign status_o     = resp.status;
  assign occupancy_o  = resp.occupancy;

endmodule

[rtl/idq_checker.sv]
// Port-level checks of the queue unit and the bind that attaches them.
// Depends on idq_pkg and indexed_double_ended_queue_unit.
`timescale 1ns / 1ps

module idq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input logic [idq_pkg::ITEM_WIDTH-1:0] read_value_o,
  input logic [idq_pkg::STAT_W-1:0]     status_o,
  input logic [idq_pkg::CNT_W-1:0]      occupancy_o
);
  import idq_pkg::*;

  // a taken request keeps the unit busy until its result
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but unit not busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a request");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> (read_value_o == '0))
    else $error("failed request returned data");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= CNT_W'(CAPACITY)))
    else $error("occupancy beyond capacity");

endmodule

bind indexed_double_ended_queue_unit idq_checker u_idq_checker (.*);
